// ----- design/bffa_pkg.sv -----
`default_nettype none

package bffa_pkg;

  localparam int DEF_NUM_BLOCKS = 1024;

  // map storage: one 32-bit word of used bits per memory row
  localparam int WORD_W = 32;

  // item field widths
  localparam int REQ_W = 2;
  localparam int IDX_W = 10;
  localparam int LEN_W = 11;
  localparam int ST_W  = 2;
  localparam int CFG_W = 11;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 16;
  localparam int APB_DW      = 32;
  localparam int APB_AW      = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_INIT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_MARK = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] STS_OK        = 2'd0;
  localparam logic [ST_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [ST_W-1:0] STS_RANGE     = 2'd2;

  // register index (paddr[2])
  localparam logic REG_TOTAL    = 1'b0;
  localparam logic REG_RESERVED = 1'b1;

  localparam logic [CFG_W-1:0] TOTAL_RST    = 11'd1024;
  localparam logic [CFG_W-1:0] RESERVED_RST = 11'd0;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_INIT,
    ST_MARK_WR,
    ST_FIND,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic            accept;     // latch request fields
    logic            rd_en;      // find: read word at waddr
    logic            rd_last;    // word read is the last one in range
    logic            rd_mark;    // read word holding block_index
    logic            wr_init;    // write init pattern at waddr
    logic            init_zero;  // init pattern forced to all free
    logic            wr_mark;    // write back word with block bit set
    logic            find_clr;   // clear run carry and scan pipeline
    logic            flush;      // drop words still in the scan pipeline
    logic            res_we;
    logic [ST_W-1:0] res_status;
    logic            res_found;  // take start from the scan hit
    logic            out_load;
  } cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic             mark_ok;
    logic             len_zero;
    logic             size_zero;
    logic             hit;
    logic             last;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/bffa_regs.sv -----
`default_nettype none

module bffa_regs (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_psel,
  input  wire logic                          cfg_penable,
  input  wire logic                          cfg_pwrite,
  input  wire logic [bffa_pkg::APB_AW-1:0]   cfg_paddr,
  input  wire logic [bffa_pkg::APB_DW-1:0]   cfg_pwdata,
  output logic      [bffa_pkg::APB_DW-1:0]   cfg_prdata,
  output logic                               cfg_pready,
  output logic      [bffa_pkg::CFG_W-1:0]    total_blocks,
  output logic      [bffa_pkg::CFG_W-1:0]    reserved_blocks
);

  logic [bffa_pkg::CFG_W-1:0] total_r;
  logic [bffa_pkg::CFG_W-1:0] total_nxt;
  logic [bffa_pkg::CFG_W-1:0] reserved_r;
  logic [bffa_pkg::CFG_W-1:0] reserved_nxt;
  logic                       wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    total_nxt    = total_r;
    reserved_nxt = reserved_r;
    if (wr_en) begin
      case (cfg_paddr[2])
        bffa_pkg::REG_TOTAL:    total_nxt    = cfg_pwdata[bffa_pkg::CFG_W-1:0];
        bffa_pkg::REG_RESERVED: reserved_nxt = cfg_pwdata[bffa_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r    <= bffa_pkg::TOTAL_RST;
      reserved_r <= bffa_pkg::RESERVED_RST;
    end else begin
      total_r    <= total_nxt;
      reserved_r <= reserved_nxt;
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      bffa_pkg::REG_TOTAL:    cfg_prdata = bffa_pkg::APB_DW'(total_r);
      bffa_pkg::REG_RESERVED: cfg_prdata = bffa_pkg::APB_DW'(reserved_r);
      default:                cfg_prdata = '0;
    endcase
  end

  assign total_blocks    = total_r;
  assign reserved_blocks = reserved_r;

endmodule

`default_nettype wire

// ----- design/bffa_dp.sv -----
`default_nettype none

module bffa_dp #(
  parameter  int NUM_BLOCKS = bffa_pkg::DEF_NUM_BLOCKS,
  localparam int NUM_WORDS  = (NUM_BLOCKS + bffa_pkg::WORD_W - 1) / bffa_pkg::WORD_W,
  localparam int WA_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire bffa_pkg::cmd_t                    cmd,
  input  wire logic [WA_W-1:0]                   waddr,
  output bffa_pkg::sts_t                         sts,
  output logic      [WA_W-1:0]                   last_word,
  input  wire logic [bffa_pkg::REQ_W-1:0]        in_req,
  input  wire logic [bffa_pkg::IDX_W-1:0]        in_idx,
  input  wire logic [bffa_pkg::LEN_W-1:0]        in_len,
  input  wire logic [bffa_pkg::CFG_W-1:0]        total_blocks,
  input  wire logic [bffa_pkg::CFG_W-1:0]        reserved_blocks,
  output logic      [bffa_pkg::ST_W-1:0]         out_status,
  output logic      [bffa_pkg::IDX_W-1:0]        out_start
);

  localparam int WORD_W    = bffa_pkg::WORD_W;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int NB_W      = $clog2(NUM_BLOCKS + 1);
  localparam int CW        = ((NB_W > bffa_pkg::LEN_W) ? NB_W : bffa_pkg::LEN_W) + 1;

  // request fields
  logic [bffa_pkg::REQ_W-1:0] req_r;
  logic [bffa_pkg::IDX_W-1:0] idx_r;
  logic [bffa_pkg::LEN_W-1:0] len_r;

  // map memory
  logic [WORD_W-1:0] map_r [NUM_WORDS];
  logic [WORD_W-1:0] rdata_r;
  logic              mem_we;
  logic              mem_re;
  logic [WA_W-1:0]   mem_wa;
  logic [WA_W-1:0]   mem_ra;
  logic [WORD_W-1:0] mem_wd;

  logic [CW-1:0]     size_cw;
  logic [CW-1:0]     rsv_cw;
  logic [CW-1:0]     total_cw;
  logic [CW-1:0]     reserved_cw;
  logic [CW-1:0]     idx_cw;
  logic [CW-1:0]     len_cw;
  logic [CW-1:0]     size_m1;
  logic [WA_W-1:0]   idx_word;
  logic [BIT_W-1:0]  idx_bit;
  logic [CW-1:0]     init_lo;
  logic [CW-1:0]     init_rem;
  logic [WORD_W-1:0] init_pat;

  // scan pipeline: stage 1 is the registered read, stage 2 the prefix result
  logic              vld1_r;
  logic              last1_r;
  logic [WA_W-1:0]   base1_r;
  logic              vld2_r;
  logic              last2_r;
  logic [WA_W-1:0]   base2_r;
  logic [WORD_W-1:0] hv_r;
  logic [BIT_W-1:0]  lp_r [WORD_W];
  logic [CW-1:0]     carry_r;
  logic [CW-1:0]     carry_nxt;

  logic [WORD_W-1:0] hv_l [BIT_W+1];
  logic [BIT_W-1:0]  lp_l [BIT_W+1][WORD_W];

  logic [WORD_W-1:0] hit_v;
  logic              hit_any;
  logic [BIT_W-1:0]  hit_pos;
  logic [CW-1:0]     run_b;
  logic [CW-1:0]     gidx_b;
  logic [CW-1:0]     start_cw;

  logic [bffa_pkg::ST_W-1:0]  res_status_r;
  logic [bffa_pkg::IDX_W-1:0] res_start_r;
  logic [bffa_pkg::ST_W-1:0]  out_status_r;
  logic [bffa_pkg::IDX_W-1:0] out_start_r;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r <= in_req;
      idx_r <= in_idx;
      len_r <= in_len;
    end
  end

  assign total_cw    = CW'(total_blocks);
  assign reserved_cw = CW'(reserved_blocks);
  assign size_cw     = (total_cw > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : total_cw;
  assign rsv_cw      = (reserved_cw > CW'(NUM_BLOCKS)) ? CW'(NUM_BLOCKS) : reserved_cw;
  assign idx_cw      = CW'(idx_r);
  assign len_cw      = CW'(len_r);
  assign size_m1     = size_cw - CW'(1);
  assign last_word   = size_m1[BIT_W +: WA_W];
  assign idx_word    = idx_cw[BIT_W +: WA_W];
  assign idx_bit     = idx_r[BIT_W-1:0];

  // init pattern: blocks below min(reserved, NUM_BLOCKS) are used
  always_comb begin
    init_lo  = CW'({waddr, {BIT_W{1'b0}}});
    init_rem = rsv_cw - init_lo;
    if (cmd.init_zero || rsv_cw <= init_lo) begin
      init_pat = '0;
    end else if (rsv_cw >= init_lo + CW'(WORD_W)) begin
      init_pat = '1;
    end else begin
      init_pat = ~({WORD_W{1'b1}} << init_rem[BIT_W-1:0]);
    end
  end

  assign mem_we = cmd.wr_init || cmd.wr_mark;
  assign mem_wa = cmd.wr_mark ? idx_word : waddr;
  assign mem_wd = cmd.wr_mark ? (rdata_r | (WORD_W'(1) << idx_bit)) : init_pat;
  assign mem_re = cmd.rd_en || cmd.rd_mark;
  assign mem_ra = cmd.rd_mark ? idx_word : waddr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_r[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r <= map_r[mem_ra];
    end
  end

  // highest used bit at or below each position, by doubling
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      hv_l[0][b] = rdata_r[b];
      lp_l[0][b] = BIT_W'(b);
    end
    for (int l = 0; l < BIT_W; l++) begin
      for (int b = 0; b < WORD_W; b++) begin
        if (b >= (1 << l) && !hv_l[l][b]) begin
          hv_l[l+1][b] = hv_l[l][b - (1 << l)];
          lp_l[l+1][b] = lp_l[l][b - (1 << l)];
        end else begin
          hv_l[l+1][b] = hv_l[l][b];
          lp_l[l+1][b] = lp_l[l][b];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else if (cmd.flush || cmd.find_clr) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= cmd.rd_en;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    last1_r <= cmd.rd_last;
    base1_r <= waddr;
    last2_r <= last1_r;
    base2_r <= base1_r;
    hv_r    <= hv_l[BIT_W];
    for (int b = 0; b < WORD_W; b++) begin
      lp_r[b] <= lp_l[BIT_W][b];
    end
  end

  // run length ending at each bit, carried in from earlier words
  always_comb begin
    hit_v  = '0;
    run_b  = '0;
    gidx_b = '0;
    for (int b = 0; b < WORD_W; b++) begin
      gidx_b = CW'({base2_r, BIT_W'(b)});
      if (hv_r[b]) begin
        run_b = CW'(b) - CW'(lp_r[b]);
      end else begin
        run_b = carry_r + CW'(b) + CW'(1);
      end
      hit_v[b] = (gidx_b < size_cw) && (run_b >= len_cw);
    end
  end

  always_comb begin
    hit_pos = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (hit_v[b]) begin
        hit_pos = BIT_W'(b);
      end
    end
  end

  assign hit_any  = |hit_v;
  assign start_cw = CW'({base2_r, hit_pos}) + CW'(1) - len_cw;

  always_comb begin
    if (hv_r[WORD_W-1]) begin
      carry_nxt = CW'(WORD_W - 1) - CW'(lp_r[WORD_W-1]);
    end else begin
      carry_nxt = carry_r + CW'(WORD_W);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find_clr) begin
      carry_r <= '0;
    end else if (vld2_r) begin
      carry_r <= carry_nxt;
    end
  end

  always_comb begin
    sts.req       = req_r;
    sts.mark_ok   = idx_cw < size_cw;
    sts.len_zero  = (len_r == '0);
    sts.size_zero = (size_cw == '0);
    sts.hit       = vld2_r && hit_any;
    sts.last      = vld2_r && last2_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status_r <= cmd.res_status;
      res_start_r  <= cmd.res_found ? start_cw[bffa_pkg::IDX_W-1:0] : '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
    end
  end

  assign out_status = out_status_r;
  assign out_start  = out_start_r;

endmodule

`default_nettype wire

// ----- design/bffa_ctrl.sv -----
`default_nettype none

module bffa_ctrl #(
  parameter  int NUM_BLOCKS = bffa_pkg::DEF_NUM_BLOCKS,
  localparam int NUM_WORDS  = (NUM_BLOCKS + bffa_pkg::WORD_W - 1) / bffa_pkg::WORD_W,
  localparam int WA_W       = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  input  wire bffa_pkg::sts_t        sts,
  input  wire logic [WA_W-1:0]       last_word,
  output bffa_pkg::cmd_t             cmd,
  output logic      [WA_W-1:0]       waddr
);

  localparam logic [WA_W-1:0] LAST_W = WA_W'(NUM_WORDS - 1);

  bffa_pkg::state_t state_r;
  bffa_pkg::state_t state_nxt;
  logic [WA_W-1:0]  wcnt_r;
  logic [WA_W-1:0]  wcnt_nxt;
  logic             issue_done_r;
  logic             issue_done_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bffa_pkg::ST_CLEAR;
      wcnt_r       <= '0;
      issue_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wcnt_r       <= wcnt_nxt;
      issue_done_r <= issue_done_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    wcnt_nxt       = wcnt_r;
    issue_done_nxt = issue_done_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    cmd            = '0;

    case (state_r)
      bffa_pkg::ST_CLEAR: begin
        cmd.wr_init   = 1'b1;
        cmd.init_zero = 1'b1;
        wcnt_nxt      = wcnt_r + WA_W'(1);
        if (wcnt_r == LAST_W) begin
          wcnt_nxt  = '0;
          state_nxt = bffa_pkg::ST_IDLE;
        end
      end

      bffa_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = bffa_pkg::ST_DISPATCH;
        end
      end

      bffa_pkg::ST_DISPATCH: begin
        wcnt_nxt = '0;
        case (sts.req)
          bffa_pkg::REQ_INIT: begin
            state_nxt = bffa_pkg::ST_INIT;
          end
          bffa_pkg::REQ_MARK: begin
            if (sts.mark_ok) begin
              cmd.rd_mark = 1'b1;
              state_nxt   = bffa_pkg::ST_MARK_WR;
            end else begin
              cmd.res_we     = 1'b1;
              cmd.res_status = bffa_pkg::STS_RANGE;
              state_nxt      = bffa_pkg::ST_DONE;
            end
          end
          bffa_pkg::REQ_FIND: begin
            if (sts.len_zero) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = bffa_pkg::STS_OK;
              state_nxt      = bffa_pkg::ST_DONE;
            end else if (sts.size_zero) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = bffa_pkg::STS_NOT_FOUND;
              state_nxt      = bffa_pkg::ST_DONE;
            end else begin
              cmd.find_clr   = 1'b1;
              issue_done_nxt = 1'b0;
              state_nxt      = bffa_pkg::ST_FIND;
            end
          end
          default: begin
            cmd.res_we     = 1'b1;
            cmd.res_status = bffa_pkg::STS_OK;
            state_nxt      = bffa_pkg::ST_DONE;
          end
        endcase
      end

      bffa_pkg::ST_INIT: begin
        cmd.wr_init = 1'b1;
        wcnt_nxt    = wcnt_r + WA_W'(1);
        if (wcnt_r == LAST_W) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = bffa_pkg::STS_OK;
          state_nxt      = bffa_pkg::ST_DONE;
        end
      end

      bffa_pkg::ST_MARK_WR: begin
        cmd.wr_mark    = 1'b1;
        cmd.res_we     = 1'b1;
        cmd.res_status = bffa_pkg::STS_OK;
        state_nxt      = bffa_pkg::ST_DONE;
      end

      bffa_pkg::ST_FIND: begin
        if (sts.hit) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = bffa_pkg::STS_OK;
          cmd.res_found  = 1'b1;
          cmd.flush      = 1'b1;
          state_nxt      = bffa_pkg::ST_DONE;
        end else if (sts.last) begin
          cmd.res_we     = 1'b1;
          cmd.res_status = bffa_pkg::STS_NOT_FOUND;
          cmd.flush      = 1'b1;
          state_nxt      = bffa_pkg::ST_DONE;
        end else if (!issue_done_r) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_last = (wcnt_r == last_word);
          wcnt_nxt    = wcnt_r + WA_W'(1);
          if (cmd.rd_last) begin
            issue_done_nxt = 1'b1;
          end
        end
      end

      bffa_pkg::ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = bffa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = bffa_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_tready  = (state_r == bffa_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign waddr      = wcnt_r;

  // no item is taken as reset is released and the clearing sweep starts
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> !in_tready)
    else $error("item accepted before clearing sweep finished");

  // the scan never reads past the last word of the disk
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bffa_pkg::ST_FIND && cmd.rd_en) |-> wcnt_r <= last_word)
    else $error("scan read beyond disk size");

  // a hit or the last word ends the search in the next cycle
  a_find_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bffa_pkg::ST_FIND && (sts.hit || sts.last)) |=> state_r == bffa_pkg::ST_DONE)
    else $error("find did not finish on hit or last word");

  // the map is never written while a search is running
  a_find_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r == bffa_pkg::ST_FIND) && state_r == bffa_pkg::ST_FIND
      |-> !cmd.wr_init && !cmd.wr_mark)
    else $error("map written during find");

endmodule

`default_nettype wire

// ----- design/bitmap_first_fit_block_allocator.sv -----
// Find reads the map one 32-bit word per cycle from a RAM with separate read and write
// addresses and checks the runs of that word in a two-stage pipeline; one request at a time,
// the next item taken only after the previous result has been loaded for output.
// Reset is synchronous, active low: a clearing sweep then frees the whole map while
// in_tready stays low.
`default_nettype none

module bitmap_first_fit_block_allocator #(
  parameter int NUM_BLOCKS = bffa_pkg::DEF_NUM_BLOCKS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  // in_tdata: [1:0] req_type, [11:2] block_index, [22:12] run_length, [23] zero
  input  wire logic [bffa_pkg::IN_TDATA_W-1:0]       in_tdata,
  input  wire logic                                  in_tvalid,
  output logic                                       in_tready,
  // out_tdata: [1:0] status, [11:2] start_block, [15:12] zero
  output logic      [bffa_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [bffa_pkg::APB_AW-1:0]           cfg_paddr,
  input  wire logic [bffa_pkg::APB_DW-1:0]           cfg_pwdata,
  output logic      [bffa_pkg::APB_DW-1:0]           cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int WORD_W    = bffa_pkg::WORD_W;
  localparam int NUM_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int WA_W      = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int IDX_LO    = bffa_pkg::REQ_W;
  localparam int LEN_LO    = bffa_pkg::REQ_W + bffa_pkg::IDX_W;
  localparam int OUT_USED  = bffa_pkg::ST_W + bffa_pkg::IDX_W;

  bffa_pkg::cmd_t               cmd;
  bffa_pkg::sts_t               sts;
  logic [WA_W-1:0]              waddr;
  logic [WA_W-1:0]              last_word;
  logic [bffa_pkg::CFG_W-1:0]   total_blocks;
  logic [bffa_pkg::CFG_W-1:0]   reserved_blocks;
  logic [bffa_pkg::ST_W-1:0]    out_status;
  logic [bffa_pkg::IDX_W-1:0]   out_start;

  bffa_regs u_regs (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_psel        (cfg_psel),
    .cfg_penable     (cfg_penable),
    .cfg_pwrite      (cfg_pwrite),
    .cfg_paddr       (cfg_paddr),
    .cfg_pwdata      (cfg_pwdata),
    .cfg_prdata      (cfg_prdata),
    .cfg_pready      (cfg_pready),
    .total_blocks    (total_blocks),
    .reserved_blocks (reserved_blocks)
  );

  bffa_ctrl #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .last_word  (last_word),
    .cmd        (cmd),
    .waddr      (waddr)
  );

  bffa_dp #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .waddr           (waddr),
    .sts             (sts),
    .last_word       (last_word),
    .in_req          (in_tdata[bffa_pkg::REQ_W-1:0]),
    .in_idx          (in_tdata[IDX_LO +: bffa_pkg::IDX_W]),
    .in_len          (in_tdata[LEN_LO +: bffa_pkg::LEN_W]),
    .total_blocks    (total_blocks),
    .reserved_blocks (reserved_blocks),
    .out_status      (out_status),
    .out_start       (out_start)
  );

  assign out_tdata = {{(bffa_pkg::OUT_TDATA_W - OUT_USED){1'b0}}, out_start, out_status};

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD = 400;
  localparam int MAP_SIZE = bffa_pkg::DEF_NUM_BLOCKS;

  // request code the block answers without doing anything
  localparam logic [bffa_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  localparam logic [bffa_pkg::APB_AW-1:0] ADDR_TOTAL    = 3'd0;
  localparam logic [bffa_pkg::APB_AW-1:0] ADDR_RESERVED = 3'd4;

  typedef struct packed {
    logic [bffa_pkg::ST_W-1:0]  status;
    logic [bffa_pkg::IDX_W-1:0] start;
  } alloc_result_t;

  logic                             clk;
  logic                             rst_n;
  logic [bffa_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic                             in_tvalid;
  logic                             in_tready;
  logic [bffa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic                             cfg_psel;
  logic                             cfg_penable;
  logic                             cfg_pwrite;
  logic [bffa_pkg::APB_AW-1:0]      cfg_paddr;
  logic [bffa_pkg::APB_DW-1:0]      cfg_pwdata;
  logic [bffa_pkg::APB_DW-1:0]      cfg_prdata;
  logic                             cfg_pready;

  // shadow of the block's state
  logic [MAP_SIZE-1:0]        used_map;
  logic [bffa_pkg::CFG_W-1:0] total_reg;
  logic [bffa_pkg::CFG_W-1:0] reserved_reg;

  alloc_result_t pending_results[$];
  int            mismatch_count = 0;
  int            readback_errors = 0;
  int            cycle_count = 0;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            hold_request = 0;
  int            hold_served = 0;
  int            hold_left = 0;

  bitmap_first_fit_block_allocator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tdata    (in_tdata),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .out_tdata   (out_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off each time one is requested
  always @(negedge clk) begin
    if (hold_served != hold_request) begin
      hold_served <= hold_request;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    alloc_result_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0d start %0d",
                 $time, out_tdata[1:0], out_tdata[11:2]);
        mismatch_count++;
      end else begin
        due = pending_results.pop_front();
        if (out_tdata[1:0] !== due.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, due.status, out_tdata[1:0]);
          mismatch_count++;
        end
        if (out_tdata[11:2] !== due.start) begin
          $display("%0t: start_block mismatch, expected %0d, actual %0d",
                   $time, due.start, out_tdata[11:2]);
          mismatch_count++;
        end
      end
    end
  end

  // Applies one request to the shadow map and returns the answer it gives.
  function automatic alloc_result_t compute_alloc_result(
      input logic [bffa_pkg::REQ_W-1:0] req,
      input logic [bffa_pkg::IDX_W-1:0] idx,
      input logic [bffa_pkg::LEN_W-1:0] len);
    alloc_result_t res;
    int disk;
    int reserve;
    int run;
    int pos;
    res.status = bffa_pkg::STS_OK;
    res.start = '0;
    disk = (total_reg > MAP_SIZE) ? MAP_SIZE : int'(total_reg);
    case (req)
      bffa_pkg::REQ_INIT: begin
        reserve = (reserved_reg > MAP_SIZE) ? MAP_SIZE : int'(reserved_reg);
        used_map = '0;
        for (pos = 0; pos < reserve; pos++) used_map[pos] = 1'b1;
      end
      bffa_pkg::REQ_MARK: begin
        if (int'(idx) < disk) used_map[idx] = 1'b1;
        else res.status = bffa_pkg::STS_RANGE;
      end
      bffa_pkg::REQ_FIND: begin
        if (len != 0) begin
          res.status = bffa_pkg::STS_NOT_FOUND;
          run = 0;
          for (pos = 0; pos < disk && res.status != bffa_pkg::STS_OK; pos++) begin
            run = used_map[pos] ? 0 : run + 1;
            if (run == int'(len)) begin
              res.status = bffa_pkg::STS_OK;
              res.start = bffa_pkg::IDX_W'(pos + 1 - int'(len));
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic send_request(input logic [bffa_pkg::REQ_W-1:0] req,
                              input logic [bffa_pkg::IDX_W-1:0] idx,
                              input logic [bffa_pkg::LEN_W-1:0] len);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, len, idx, req};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(compute_alloc_result(req, idx, len));
  endtask

  // Sender pauses until every outstanding result has been taken.
  task automatic wait_idle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic program_register(input logic [bffa_pkg::APB_AW-1:0] addr,
                                  input logic [bffa_pkg::CFG_W-1:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= bffa_pkg::APB_DW'(value);
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (addr == ADDR_TOTAL) total_reg = value;
    else reserved_reg = value;
    @(negedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata[bffa_pkg::CFG_W-1:0] !== value) begin
      $display("%0t: readback at 0x%0h, expected %0d, actual %0d",
               $time, addr, value, cfg_prdata[bffa_pkg::CFG_W-1:0]);
      readback_errors++;
    end
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic configure(input logic [bffa_pkg::CFG_W-1:0] total,
                           input logic [bffa_pkg::CFG_W-1:0] reserved);
    wait_idle();
    program_register(ADDR_TOTAL, total);
    program_register(ADDR_RESERVED, reserved);
  endtask

  task automatic test_directed();
    send_idle_pct = 35;
    recv_idle_pct = 82;
    configure(11'd1024, 11'd0);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd0);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1024);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1025);
    send_request(bffa_pkg::REQ_MARK, 10'd0, '0);
    send_request(bffa_pkg::REQ_MARK, 10'd1023, '0);
    send_request(bffa_pkg::REQ_FIND, '1, 11'd1);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1022);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1023);
    send_request(REQ_UNUSED, '1, '1);
    send_request(bffa_pkg::REQ_INIT, '1, '1);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1024);
    // empty disk, reserve beyond the map
    configure(11'd0, 11'd2047);
    send_request(bffa_pkg::REQ_INIT, '0, '0);
    send_request(bffa_pkg::REQ_MARK, 10'd0, '0);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd0);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1);
    // disk size above the map gets clipped
    configure(11'd2047, 11'd1024);
    send_request(bffa_pkg::REQ_INIT, '0, '0);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1);
    send_request(bffa_pkg::REQ_MARK, 10'd1023, '0);
    // one-block disk
    configure(11'd1, 11'd0);
    send_request(bffa_pkg::REQ_INIT, '0, '0);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1);
    send_request(bffa_pkg::REQ_MARK, 10'd1, '0);
    send_request(bffa_pkg::REQ_MARK, 10'd0, '0);
    send_request(bffa_pkg::REQ_FIND, '0, 11'd1);
  endtask

  task automatic send_random_item();
    int kind;
    int disk;
    logic [bffa_pkg::IDX_W-1:0] idx;
    logic [bffa_pkg::LEN_W-1:0] len;
    kind = $urandom_range(0, 99);
    disk = (total_reg > MAP_SIZE) ? MAP_SIZE : int'(total_reg);
    idx = bffa_pkg::IDX_W'($urandom);
    len = bffa_pkg::LEN_W'($urandom);
    if (kind < 45) begin
      // crowd the low end so finds must skip fragments
      if (disk > 0 && $urandom_range(0, 9) < 5)
        idx = bffa_pkg::IDX_W'($urandom_range(0, (disk < 128 ? disk : 128) - 1));
      else if (disk > 0 && $urandom_range(0, 9) < 7)
        idx = bffa_pkg::IDX_W'($urandom_range(0, disk - 1));
      send_request(bffa_pkg::REQ_MARK, idx, len);
    end else if (kind < 92) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: len = bffa_pkg::LEN_W'($urandom_range(1, 12));
        6, 7:             len = bffa_pkg::LEN_W'($urandom_range(13, 128));
        8:                len = bffa_pkg::LEN_W'($urandom_range(0, 1025));
        default:          ;
      endcase
      send_request(bffa_pkg::REQ_FIND, idx, len);
    end else if (kind < 96) begin
      send_request(bffa_pkg::REQ_INIT, idx, len);
    end else begin
      send_request(REQ_UNUSED, idx, len);
    end
  endtask

  task automatic test_random_traffic(input int num_items, input int snd_idle,
                                     input int rcv_idle);
    int sent;
    int session_left;
    logic [bffa_pkg::CFG_W-1:0] total;
    logic [bffa_pkg::CFG_W-1:0] reserved;
    sent = 0;
    while (sent < num_items) begin
      wait_idle();
      send_idle_pct = snd_idle;
      recv_idle_pct = rcv_idle;
      case ($urandom_range(0, 5))
        0, 5:    total = 11'd1024;
        1:       total = bffa_pkg::CFG_W'($urandom_range(1, 64));
        2:       total = bffa_pkg::CFG_W'($urandom_range(1, 1024));
        3:       total = bffa_pkg::CFG_W'($urandom_range(1025, 2047));
        default: total = bffa_pkg::CFG_W'($urandom_range(0, 2047));
      endcase
      case ($urandom_range(0, 7))
        0:       reserved = 11'd0;
        5:       reserved = bffa_pkg::CFG_W'($urandom_range(0, 2047));
        6:       reserved = total;
        7:       reserved = bffa_pkg::CFG_W'($urandom_range(0, 300));
        default: reserved = bffa_pkg::CFG_W'($urandom_range(0, 40));
      endcase
      configure(total, reserved);
      send_request(bffa_pkg::REQ_INIT, bffa_pkg::IDX_W'($urandom),
                   bffa_pkg::LEN_W'($urandom));
      sent++;
      session_left = $urandom_range(20, 80);
      while (session_left > 0 && sent < num_items) begin
        send_random_item();
        session_left--;
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    int n;
    configure(11'd1024, 11'd16);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_request(bffa_pkg::REQ_INIT, '0, '0);
    @(posedge clk);
    hold_request++;
    for (n = 0; n < 12; n++) send_random_item();
    wait_idle();
    for (n = 0; n < 6; n++) send_random_item();
    wait_idle();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    used_map = '0;
    total_reg = bffa_pkg::TOTAL_RST;
    reserved_reg = bffa_pkg::RESERVED_RST;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(250, 35, 82);
    test_random_traffic(250, 82, 35);
    test_backpressure();
    test_random_traffic(100, 0, 0);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && readback_errors == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/bffa_pkg.sv
design/bffa_regs.sv
design/bffa_dp.sv
design/bffa_ctrl.sv
design/bitmap_first_fit_block_allocator.sv
tb/testbench.sv
